>>> rtl/m3i_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Used by m3i_cofactor, m3i_div_lane and matrix3_inverse. No dependencies.
package m3i_pkg;

  // Port field width and entry count
  localparam int IO_W  = 32;
  localparam int N_ENT = 9;

  // Defaults for the top-level parameters
  localparam int ENTRY_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Input request: one matrix, column-major
  typedef struct packed {
    logic signed [IO_W-1:0] a_r0c0;
    logic signed [IO_W-1:0] a_r1c0;
    logic signed [IO_W-1:0] a_r2c0;
    logic signed [IO_W-1:0] a_r0c1;
    logic signed [IO_W-1:0] a_r1c1;
    logic signed [IO_W-1:0] a_r2c1;
    logic signed [IO_W-1:0] a_r0c2;
    logic signed [IO_W-1:0] a_r1c2;
    logic signed [IO_W-1:0] a_r2c2;
  } in_req_t;

  // Output request: inverse, row-major, plus flags
  typedef struct packed {
    logic signed [IO_W-1:0] q_r0c0;
    logic signed [IO_W-1:0] q_r0c1;
    logic signed [IO_W-1:0] q_r0c2;
    logic signed [IO_W-1:0] q_r1c0;
    logic signed [IO_W-1:0] q_r1c1;
    logic signed [IO_W-1:0] q_r1c2;
    logic signed [IO_W-1:0] q_r2c0;
    logic signed [IO_W-1:0] q_r2c1;
    logic signed [IO_W-1:0] q_r2c2;
    logic                   singular;
    logic                   saturated;
  } out_req_t;

endpackage

>>> rtl/matrix3_inverse.sv
// 3x3 fixed-point matrix inverse by the adjugate.
// Throughput: one matrix per cycle while not stalled; nine division lanes run
// side by side, each a pipeline of one quotient bit per stage; per-stage enables.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Depends on m3i_pkg, m3i_cofactor, m3i_div_lane.
module matrix3_inverse import m3i_pkg::*; #(
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  localparam int W   = ENTRY_WIDTH;
  localparam int PRE = 4;
  localparam int LS  = W + 3;
  localparam int NS  = PRE + LS + 1;
  localparam int CFW = 2*W + 1;
  localparam int DTW = 3*W + 3;
  localparam int DW  = 3*W;

  logic [NS-1:0]         v_r;
  logic [NS-1:0]         v_nxt;
  logic [NS-1:0]         en;
  logic signed [IO_W-1:0] ent [N_ENT];
  logic signed [CFW-1:0] cof [N_ENT];
  logic signed [DTW-1:0] det;
  logic [DTW-1:0]        det_abs;
  logic [DW-1:0]         den_r [W+1];
  logic [LS-1:0]         zero_r;
  logic [W-1:0]          lq [N_ENT];
  logic [N_ENT-1:0]      lsat;
  logic [IO_W-1:0]       qx [N_ENT];
  out_req_t              out_r;

  // A stage advances when the output drains or a bubble sits at or after it
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = out_ready || !(&v_r[NS-1:s]);
  end

  assign v_nxt = {v_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_nxt[s];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // Unpack request, column-major
  assign ent[0] = in_data.a_r0c0;
  assign ent[1] = in_data.a_r1c0;
  assign ent[2] = in_data.a_r2c0;
  assign ent[3] = in_data.a_r0c1;
  assign ent[4] = in_data.a_r1c1;
  assign ent[5] = in_data.a_r2c1;
  assign ent[6] = in_data.a_r0c2;
  assign ent[7] = in_data.a_r1c2;
  assign ent[8] = in_data.a_r2c2;

  m3i_cofactor #(.W(W)) u_cof (
    .clk   (clk),
    .en_i  (en[PRE-1:0]),
    .ent_i (ent),
    .cof_o (cof),
    .det_o (det)
  );

  // Shared divisor and singular flag, carried alongside the lanes
  assign det_abs = det[DTW-1] ? -det : det;

  always_ff @(posedge clk) begin
    if (en[PRE]) begin
      den_r[0]  <= det_abs[DW-1:0];
      zero_r[0] <= (det == '0);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_den
    always_ff @(posedge clk) begin
      if (en[PRE+k]) den_r[k] <= den_r[k-1];
    end
  end

  for (genvar k = 1; k < LS; k++) begin : g_zero
    always_ff @(posedge clk) begin
      if (en[PRE+k]) zero_r[k] <= zero_r[k-1];
    end
  end

  // Nine division lanes
  for (genvar n = 0; n < N_ENT; n++) begin : g_lane
    m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk       (clk),
      .en_i      (en[PRE+LS-1:PRE]),
      .cof_i     (cof[n]),
      .det_neg_i (det[DTW-1]),
      .den_i     (den_r),
      .q_o       (lq[n]),
      .sat_o     (lsat[n])
    );
    assign qx[n] = zero_r[LS-1] ? '0 : IO_W'($signed(lq[n]));
  end

  // Merge lanes into the output register
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r.q_r0c0    <= qx[0];
      out_r.q_r0c1    <= qx[1];
      out_r.q_r0c2    <= qx[2];
      out_r.q_r1c0    <= qx[3];
      out_r.q_r1c1    <= qx[4];
      out_r.q_r1c2    <= qx[5];
      out_r.q_r2c0    <= qx[6];
      out_r.q_r2c1    <= qx[7];
      out_r.q_r2c2    <= qx[8];
      out_r.singular  <= zero_r[LS-1];
      out_r.saturated <= !zero_r[LS-1] && (|lsat);
    end
  end

  assign out_data = out_r;

  // Checks
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      !out_data.saturated && out_data.q_r0c0 == '0 && out_data.q_r2c2 == '0)
    else $error("singular result with nonzero payload");

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request lost at first stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !v_r[NS-2] |=> !out_valid)
    else $error("result repeated after drain");

endmodule

>>> rtl/m3i_cofactor.sv
// Cofactor and determinant front end: four pipeline stages.
// Depends on m3i_pkg.
module m3i_cofactor import m3i_pkg::*; #(
  parameter int W = ENTRY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic [3:0]             en_i,
  input  logic signed [IO_W-1:0] ent_i [N_ENT],
  output logic signed [2*W:0]    cof_o [N_ENT],
  output logic signed [3*W+2:0]  det_o
);

  localparam int PW  = 2*W;
  localparam int CFW = 2*W+1;
  localparam int DTW = 3*W+3;

  logic signed [W-1:0]   e       [N_ENT];
  logic signed [PW-1:0]  pa_r    [N_ENT];
  logic signed [PW-1:0]  pb_r    [N_ENT];
  logic signed [CFW-1:0] cof1_r  [N_ENT];
  logic signed [CFW-1:0] cof2_r  [N_ENT];
  logic signed [CFW-1:0] cof3_r  [N_ENT];
  logic signed [W-1:0]   ez0_r   [3];
  logic signed [W-1:0]   ez1_r   [3];
  logic signed [CFW-1:0] plo_r   [3];
  logic signed [CFW-1:0] phi_r   [3];
  logic signed [DTW-1:0] det_nxt;
  logic signed [DTW-1:0] det_r;

  // Entries sign-extended from their low W bits
  for (genvar n = 0; n < N_ENT; n++) begin : g_ent
    assign e[n] = ent_i[n][W-1:0];
  end

  // Cofactor k,j: columns (k+1, k+2), rows (j+1, j+2), all mod 3
  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int N  = 3*k + j;
      localparam int CA = (k+1) % 3;
      localparam int CB = (k+2) % 3;
      localparam int R1 = (j+1) % 3;
      localparam int R2 = (j+2) % 3;

      always_ff @(posedge clk) begin
        // stage 0: products
        if (en_i[0]) begin
          pa_r[N] <= e[3*CA+R1] * e[3*CB+R2];
          pb_r[N] <= e[3*CA+R2] * e[3*CB+R1];
        end
        // stage 1: difference
        if (en_i[1]) begin
          cof1_r[N] <= {pa_r[N][PW-1], pa_r[N]} - {pb_r[N][PW-1], pb_r[N]};
        end
        if (en_i[2]) cof2_r[N] <= cof1_r[N];
        if (en_i[3]) cof3_r[N] <= cof2_r[N];
      end
    end
  end

  // Determinant: (c0 x c1) . c2, cofactor split into low and high halves
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en_i[0]) ez0_r[j] <= e[6+j];
      if (en_i[1]) ez1_r[j] <= ez0_r[j];
      if (en_i[2]) begin
        plo_r[j] <= $signed({1'b0, cof1_r[6+j][W-1:0]}) * ez1_r[j];
        phi_r[j] <= $signed(cof1_r[6+j][CFW-1:W]) * ez1_r[j];
      end
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DTW'(phi_r[j]) <<< W) + DTW'(plo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[3]) det_r <= det_nxt;
  end

  assign cof_o = cof3_r;
  assign det_o = det_r;

endmodule

>>> rtl/m3i_div_lane.sv
// One division lane: scaled cofactor magnitude over |det|, one quotient bit
// per stage, then sign and saturation. Depends on m3i_pkg.
module m3i_div_lane import m3i_pkg::*; #(
  parameter int W = ENTRY_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic [W+2:0]        en_i,
  input  logic signed [2*W:0] cof_i,
  input  logic                det_neg_i,
  input  logic [3*W-1:0]      den_i [W+1],
  output logic [W-1:0]        q_o,
  output logic                sat_o
);

  localparam int MW = 2*W;
  localparam int NW = 2*W + 2*F;
  localparam int DW = 3*W;
  localparam int CW = (NW > DW+W) ? NW : DW+W;

  logic [2*W:0]  cabs;
  logic [NW-1:0] num_r;
  logic          neg_r  [W+2];
  logic [NW-1:0] rem_r  [W+1];
  logic [W-1:0]  quo_r  [W+1];
  logic          ovf_r  [W+1];
  logic [W-1:0]  lim;
  logic          over;
  logic [W-1:0]  mag;
  logic [W-1:0]  val;
  logic [W-1:0]  q_r;
  logic          sat_r;

  assign cabs = cof_i[2*W] ? -cof_i : cof_i;

  // Stage 0: numerator and result sign; stage 1: overflow check
  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      num_r    <= NW'(cabs[MW-1:0]) << (2*F);
      neg_r[0] <= cof_i[2*W] ^ det_neg_i;
    end
    if (en_i[1]) begin
      ovf_r[0] <= CW'(num_r) >= (CW'(den_i[0]) << W);
      rem_r[0] <= num_r;
      quo_r[0] <= '0;
      neg_r[1] <= neg_r[0];
    end
  end

  // Restoring steps, MSB first
  for (genvar t = 1; t <= W; t++) begin : g_step
    localparam int SH = W - t;
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(den_i[t]) << SH;
    assign take  = CW'(rem_r[t-1]) >= trial;

    always_ff @(posedge clk) begin
      if (en_i[t+1]) begin
        rem_r[t]   <= take ? NW'(CW'(rem_r[t-1]) - trial) : rem_r[t-1];
        quo_r[t]   <= quo_r[t-1] | (W'(take) << SH);
        ovf_r[t]   <= ovf_r[t-1];
        neg_r[t+1] <= neg_r[t];
      end
    end
  end

  // Clip to the signed range, then apply sign
  always_comb begin
    lim  = neg_r[W+1] ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
    over = ovf_r[W] || (quo_r[W] > lim);
    mag  = over ? lim : quo_r[W];
    val  = neg_r[W+1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en_i[W+2]) begin
      q_r   <= val;
      sat_r <= over;
    end
  end

  assign q_o   = q_r;
  assign sat_o = sat_r;

endmodule

>>> tb/matrix3_inverse_tb.sv
// Self-checking testbench for matrix3_inverse: random and directed 3x3 Q16.16 matrices,
// expected inverses computed in exact wide integer arithmetic. Depends on m3i_pkg and the RTL.
module matrix3_inverse_tb;
  import m3i_pkg::*;

  localparam int N_ITEMS = 1050;
  localparam int DRAIN   = 60;
  localparam int OW      = $bits(out_req_t);
  localparam int IW      = $bits(in_req_t);

  // Scoreboard: exact adjugate inverse, queue of pending inverses
  class inverse_board;
    out_req_t pending_inv[$];
    int       mismatches;

    function out_req_t invert3(in_req_t m);
      logic [IW-1:0]       raw;
      logic [OW-1:0]       res;
      logic signed [127:0] e[3][3];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det;
      logic [127:0]        num, den, q, lim;
      logic [31:0]         v;
      logic                neg, sat;
      int                  a, b;
      raw = m;
      res = '0;
      sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          e[c][r] = $signed(raw[IW-1-IO_W*(3*c+r) -: IO_W]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        a = (k + 1) % 3;
        b = (k + 2) % 3;
        cof[k][0] = e[a][1] * e[b][2] - e[a][2] * e[b][1];
        cof[k][1] = e[a][2] * e[b][0] - e[a][0] * e[b][2];
        cof[k][2] = e[a][0] * e[b][1] - e[a][1] * e[b][0];
      end
      det = cof[2][0] * e[2][0] + cof[2][1] * e[2][1] + cof[2][2] * e[2][2];
      if (det == 0) begin
        res[1] = 1'b1;
        return out_req_t'(res);
      end
      den = det < 0 ? -det : det;
      for (int k = 0; k < 9; k++) begin
        neg = (cof[k/3][k%3] < 0) != (det < 0);
        num = (cof[k/3][k%3] < 0 ? -cof[k/3][k%3] : cof[k/3][k%3]);
        num = num << 32;
        q   = num / den;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
          q   = lim;
          sat = 1'b1;
        end
        v = neg ? -q[31:0] : q[31:0];
        res[OW-1-IO_W*k -: IO_W] = v;
      end
      res[0] = sat;
      return out_req_t'(res);
    endfunction

    function void note_matrix(in_req_t m);
      pending_inv.push_back(invert3(m));
    endfunction

    function void check_inverse(out_req_t got);
      logic [OW-1:0] g, x;
      string         nm[11];
      out_req_t      want;
      nm = '{"q_r0c0", "q_r0c1", "q_r0c2", "q_r1c0", "q_r1c1", "q_r1c2",
             "q_r2c0", "q_r2c1", "q_r2c2", "singular", "saturated"};
      if (pending_inv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_inv.pop_front();
      g = got;
      x = want;
      for (int k = 0; k < 11; k++) begin
        logic [31:0] gf, xf;
        gf = k < 9 ? g[OW-1-IO_W*k -: IO_W] : {31'd0, g[10-k]};
        xf = k < 9 ? x[OW-1-IO_W*k -: IO_W] : {31'd0, x[10-k]};
        if (gf !== xf) begin
          mismatches++;
          if (mismatches <= 10) $display("%s: expected %h, got %h", nm[k], xf, gf);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_data;

  inverse_board board;

  matrix3_inverse i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("matrix3_inverse_tb: done, errors");
    $finish;
  end

  // Wait drawn per request; every 64 requests the side flips between random waits and no waits
  function automatic int draw_wait(int n);
    return ((n / 64) % 2 == 1) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic in_req_t mat(int e0, e1, e2, e3, e4, e5, e6, e7, e8);
    return {e0, e1, e2, e3, e4, e5, e6, e7, e8};
  endfunction

  // Entry drawn from one of several value classes
  function automatic int pick_entry(int kind);
    int extremes[7];
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, -1, 32'h0001_0000, 32'hffff_0000};
    case (kind)
      0: begin
        return $urandom;
      end
      1: begin
        return $signed($urandom_range(0, 32'h3ffff)) - 32'h20000;
      end
      2: begin
        return $signed($urandom_range(0, 511)) - 256;
      end
      default: begin
        return extremes[$urandom_range(0, 6)];
      end
    endcase
  endfunction

  function automatic in_req_t random_matrix();
    int e[9];
    int kind, sel;
    sel = $urandom_range(0, 9);
    kind = sel < 2 ? 0 : sel < 6 ? 1 : sel < 8 ? 2 : 3;
    foreach (e[i]) e[i] = pick_entry(kind);
    if (kind == 1) begin
      // Mostly well-conditioned: strong diagonal
      e[0] += 32'h40000;
      e[4] -= 32'h30000;
      e[8] += 32'h50000;
    end
    if ($urandom_range(0, 9) == 0) begin
      // Singular: third column is sum of the first two
      for (int i = 0; i < 6; i++) e[i] = pick_entry(2);
      for (int r = 0; r < 3; r++) e[6+r] = e[r] + e[3+r];
    end
    return mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  task automatic send_matrix(in_req_t m, int n);
    int gap;
    gap = draw_wait(n);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    board.note_matrix(m);
  endtask

  // Result side: random stalls, check each accepted result
  initial begin
    int n, stall;
    out_ready = 1'b0;
    n = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = draw_wait(n + 32);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_inverse(out_data);
      n++;
    end
  end

  initial begin
    in_req_t dir[$];
    int      n, wait_cnt;
    board    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, zero, extremes, tiny diagonal, rank-deficient
    dir.push_back(mat(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
    dir.push_back(mat(32'hffff_0000, 0, 0, 0, 32'hffff_0000, 0, 0, 0, 32'hffff_0000));
    dir.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
    dir.push_back(mat(-1, 0, 0, 0, 1, 0, 0, 0, -1));
    dir.push_back(mat(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
    dir.push_back(mat(32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff));
    dir.push_back(mat(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 1,
                      0, 1, 32'h8000_0000));
    dir.push_back(mat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000));
    dir.push_back(mat(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000));
    dir.push_back(mat(32'h20000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h10000));
    dir.push_back(mat(32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
                      32'h70000, 32'h80000, 32'h90000));
    dir.push_back(mat(0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
    dir.push_back(mat(32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0,
                      32'h10000));
    dir.push_back(mat(3, -2, 5, 7, 1, -4, 2, 6, -1));
    dir.push_back(mat(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff));
    dir.push_back(mat(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987, 1, 0,
                      32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h3333_3333));
    n = 0;
    foreach (dir[i]) begin
      send_matrix(dir[i], n);
      n++;
    end
    while (n < N_ITEMS) begin
      send_matrix(random_matrix(), n);
      n++;
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (board.pending_inv.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN) @(posedge clk);
    if (board.mismatches == 0 && board.pending_inv.size() == 0) begin
      $display("matrix3_inverse_tb: done, clean");
    end else begin
      $display("matrix3_inverse_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/m3i_pkg.sv
rtl/m3i_cofactor.sv
rtl/m3i_div_lane.sv
rtl/matrix3_inverse.sv
tb/matrix3_inverse_tb.sv
